[rtl/gnpo_pkg.sv]
package gnpo_pkg;

  localparam int MAX_POINTS = 4096;
  localparam int COORD_W    = 10;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int SQ_W       = 2 * COORD_W;
  localparam int DIST_W     = SQ_W + 1;
  // live flag, row, col
  localparam int ENTRY_W    = 1 + 2 * COORD_W;

  typedef logic [COORD_W-1:0] coord_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TAKE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

[rtl/gnpo_in_if.sv]
interface gnpo_in_if;
  logic             valid;
  logic             ready;
  gnpo_pkg::op_t    operation;
  gnpo_pkg::coord_t row;
  gnpo_pkg::coord_t col;

  modport source (output valid, output operation, output row, output col, input ready);
  modport sink   (input valid, input operation, input row, input col, output ready);
endinterface

[rtl/gnpo_out_if.sv]
interface gnpo_out_if;
  logic              valid;
  logic              ready;
  gnpo_pkg::coord_t  out_row;
  gnpo_pkg::coord_t  out_col;
  gnpo_pkg::status_t status;

  modport source (output valid, output out_row, output out_col, output status, input ready);
  modport sink   (input valid, input out_row, input out_col, input status, output ready);
endinterface

[rtl/greedy_nearest_point_order_core.sv]
// Greedy nearest-neighbour point orderer. Load beats add a point to a pool of up to
// MAX_POINTS entries (slots are used in load order and are not reused until reset; a load
// into a full pool is dropped and answered with status FULL). Take beats return the next
// point in greedy order: the first take returns the first point loaded, each later take
// returns the first remaining point within squared distance 1 of the last one returned,
// or else the earliest remaining point at the smallest squared distance. Every input beat
// yields exactly one output beat. A take walks the point memory in load order at one entry
// per cycle through a single read port, covering the N slots filled since reset (at most
// MAX_POINTS), and ends early once a point at distance 0 or 1 is found. One item is in
// flight at a time; a result may sit in the output register while the next beat is taken,
// provided the output side frees it in that cycle. No clearing pass is needed after reset:
// the fill count marks which memory entries hold valid data.
module greedy_nearest_point_order_core (
  input  logic clk,
  input  logic rst,
  gnpo_in_if.sink    in_ch,
  gnpo_out_if.source out_ch
);
  import gnpo_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state, state_next;

  // point memory: live flag plus coordinates
  logic [ENTRY_W-1:0] mem [MAX_POINTS];
  logic [ENTRY_W-1:0] rd_q;
  logic [ADDR_W-1:0]  rd_addr;
  logic               we;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  logic [CNT_W-1:0]   loaded_count;
  coord_t             cur_row, cur_col;
  logic               started;

  // scan pipeline
  logic [CNT_W-1:0]   issue_idx;
  logic               issue;
  logic               a_valid;
  logic [ADDR_W-1:0]  a_idx;
  logic               b_valid, b_live;
  logic [ADDR_W-1:0]  b_idx;
  coord_t             b_row, b_col;
  logic [SQ_W-1:0]    b_sqr, b_sqc;
  logic               found, hit;
  logic [DIST_W-1:0]  best;
  logic [ADDR_W-1:0]  pick_idx;
  coord_t             pick_row, pick_col;

  // output register
  logic               ovalid;
  coord_t             orow, ocol;
  status_t            ostatus;
  logic               out_free;

  logic               accept, load_acc, take_acc, pool_full, scan_done;
  coord_t             q_row, q_col, dr, dc;
  logic [DIST_W-1:0]  d_cur, best_new;
  logic               cand, take_cand;

  assign out_free     = !ovalid || out_ch.ready;
  assign in_ch.ready  = (state == S_IDLE) && out_free;
  assign accept       = in_ch.valid && in_ch.ready;
  assign load_acc     = accept && (in_ch.operation == OP_LOAD);
  assign take_acc     = accept && (in_ch.operation == OP_TAKE);
  assign pool_full    = (loaded_count >= CNT_W'(MAX_POINTS));

  assign out_ch.valid   = ovalid;
  assign out_ch.out_row = orow;
  assign out_ch.out_col = ocol;
  assign out_ch.status  = ostatus;

  // memory output split; distance terms from the last returned point
  assign q_row = rd_q[2*COORD_W-1:COORD_W];
  assign q_col = rd_q[COORD_W-1:0];
  assign dr    = (q_row > cur_row) ? q_row - cur_row : cur_row - q_row;
  assign dc    = (q_col > cur_col) ? q_col - cur_col : cur_col - q_col;

  // before the first return any live slot counts as a match
  assign d_cur     = started ? (DIST_W'(b_sqr) + DIST_W'(b_sqc)) : '0;
  assign cand      = (state == S_SCAN) && b_valid && b_live && !hit;
  assign take_cand = cand && (!found || d_cur < best);
  assign best_new  = take_cand ? d_cur : best;

  assign issue     = (state == S_SCAN) && !hit && (issue_idx < loaded_count);
  assign rd_addr   = issue_idx[ADDR_W-1:0];
  assign scan_done = hit || (!issue && !a_valid && !b_valid);

  // write port: loads append, a finished take clears the live flag of its pick
  always_comb begin
    we      = 1'b0;
    wr_addr = loaded_count[ADDR_W-1:0];
    wr_data = {1'b1, in_ch.row, in_ch.col};
    if (load_acc && !pool_full) begin
      we = 1'b1;
    end else if (state == S_FINISH && out_free && found) begin
      we      = 1'b1;
      wr_addr = pick_idx;
      wr_data = {1'b0, pick_row, pick_col};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (take_acc) state_next = S_SCAN;
      S_SCAN:   if (scan_done) state_next = S_FINISH;
      S_FINISH: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      loaded_count <= '0;
      cur_row      <= '0;
      cur_col      <= '0;
      started      <= 1'b0;
      a_valid      <= 1'b0;
      b_valid      <= 1'b0;
      found        <= 1'b0;
      hit          <= 1'b0;
      issue_idx    <= '0;
      ovalid       <= 1'b0;
    end else begin
      state <= state_next;

      if (load_acc && !pool_full) begin
        loaded_count <= loaded_count + 1'b1;
      end

      // scan pipeline: issue -> memory data -> squares -> compare
      a_valid <= issue;
      b_valid <= a_valid && (state == S_SCAN);

      if (take_acc) begin
        issue_idx <= '0;
        found     <= 1'b0;
        hit       <= 1'b0;
      end else begin
        if (issue) begin
          issue_idx <= issue_idx + 1'b1;
        end
        if (take_cand) begin
          found <= 1'b1;
        end
        if (cand && best_new <= DIST_W'(1)) begin
          hit <= 1'b1;
        end
      end

      if (state == S_FINISH && out_free && found) begin
        cur_row <= pick_row;
        cur_col <= pick_col;
        started <= 1'b1;
      end

      if (load_acc || (state == S_FINISH && out_free)) begin
        ovalid <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    a_idx  <= rd_addr;
    b_idx  <= a_idx;
    b_live <= rd_q[ENTRY_W-1];
    b_row  <= q_row;
    b_col  <= q_col;
    b_sqr  <= SQ_W'(dr * dr);
    b_sqc  <= SQ_W'(dc * dc);

    if (take_cand) begin
      best     <= d_cur;
      pick_idx <= b_idx;
      pick_row <= b_row;
      pick_col <= b_col;
    end

    if (load_acc) begin
      orow    <= '0;
      ocol    <= '0;
      ostatus <= pool_full ? ST_FULL : ST_OK;
    end else if (state == S_FINISH && out_free) begin
      orow    <= found ? pick_row : '0;
      ocol    <= found ? pick_col : '0;
      ostatus <= found ? ST_OK : ST_EMPTY;
    end
  end

endmodule

[verif/greedy_nearest_point_order_core_tb.sv]
`timescale 1ns / 100ps

module greedy_nearest_point_order_core_tb;
  import gnpo_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  // A take over a full pool walks ~MAX_POINTS entries with no beat moving.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 32;
  localparam int RANDOM_BEATS   = 100;
  localparam int PROBE_ROWS     = 24;

  typedef struct packed {
    coord_t  row;
    coord_t  col;
    status_t status;
  } point_reply_t;

  // Reply typed in by hand for the directed rows where it is obvious.
  typedef struct packed {
    logic         pinned;
    point_reply_t reply;
  } pinned_note_t;

  typedef struct packed {
    op_t          op;
    coord_t       row;
    coord_t       col;
    logic         pinned;
    point_reply_t reply;
  } probe_row_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_COIN,
    RX_PERIODIC,
    RX_SPARSE
  } rx_mode_t;

  localparam point_reply_t LOAD_OK    = '{10'd0, 10'd0, ST_OK};
  localparam point_reply_t POOL_EMPTY = '{10'd0, 10'd0, ST_EMPTY};

  // Directed opening: empty take, corner points, first take, distance-1 early exit,
  // distance ties (earliest slot wins), a duplicate at distance 0, draining to empty
  // and a reload after the drain. Coordinates on takes are don't-care, so they carry
  // assorted values, some in alternating bit patterns, to show they are ignored.
  localparam probe_row_t PROBE_TABLE [PROBE_ROWS] = '{
    '{OP_TAKE, 10'd1023, 10'd1023, 1'b1, POOL_EMPTY},
    '{OP_LOAD, 10'd1023, 10'd1023, 1'b1, LOAD_OK},
    '{OP_LOAD, 10'd0,    10'd0,    1'b1, LOAD_OK},
    '{OP_LOAD, 10'd0,    10'd1023, 1'b1, LOAD_OK},
    '{OP_LOAD, 10'd1023, 10'd0,    1'b1, LOAD_OK},
    '{OP_LOAD, 10'd512,  10'd512,  1'b1, LOAD_OK},
    '{OP_TAKE, 10'd0,    10'd0,    1'b1, '{10'd1023, 10'd1023, ST_OK}},
    '{OP_TAKE, 10'd682,  10'd341,  1'b0, LOAD_OK},
    '{OP_LOAD, 10'd513,  10'd512,  1'b1, LOAD_OK},
    '{OP_LOAD, 10'd511,  10'd512,  1'b1, LOAD_OK},
    '{OP_TAKE, 10'd341,  10'd682,  1'b0, LOAD_OK},
    '{OP_TAKE, 10'd0,    10'd0,    1'b0, LOAD_OK},
    '{OP_LOAD, 10'd514,  10'd512,  1'b1, LOAD_OK},
    '{OP_LOAD, 10'd511,  10'd509,  1'b1, LOAD_OK},
    '{OP_TAKE, 10'd1023, 10'd0,    1'b0, LOAD_OK},
    '{OP_LOAD, 10'd514,  10'd512,  1'b1, LOAD_OK},
    '{OP_TAKE, 10'd0,    10'd1023, 1'b0, LOAD_OK},
    '{OP_TAKE, 10'd1,    10'd2,    1'b0, LOAD_OK},
    '{OP_TAKE, 10'd512,  10'd256,  1'b0, LOAD_OK},
    '{OP_TAKE, 10'd128,  10'd64,   1'b0, LOAD_OK},
    '{OP_TAKE, 10'd32,   10'd16,   1'b0, LOAD_OK},
    '{OP_TAKE, 10'd8,    10'd4,    1'b1, POOL_EMPTY},
    '{OP_LOAD, 10'd1,    10'd0,    1'b1, LOAD_OK},
    '{OP_TAKE, 10'd1023, 10'd1023, 1'b0, LOAD_OK}
  };

  logic clk;
  logic rst;

  gnpo_in_if  in_bus ();
  gnpo_out_if out_bus ();

  greedy_nearest_point_order_core u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the pool: slots fill in load order and are never reused.
  // ---------------------------------------------------------------------------
  coord_t pool_row  [MAX_POINTS];
  coord_t pool_col  [MAX_POINTS];
  logic   pool_live [MAX_POINTS];
  int     fill_count;
  int     live_count;
  coord_t last_row;
  coord_t last_col;
  logic   have_last;

  // Run statistics for the closing summary.
  int n_load;
  int n_full;
  int n_take;
  int n_empty;

  point_reply_t awaited_replies [$];
  pinned_note_t pinned_notes [$];
  int           mismatches;

  // Sender / receiver coordination.
  int   burst_left;
  logic hold_req;

  coord_t walk_row;
  coord_t walk_col;

  // Next point in greedy order, or the load outcome; updates the shadow pool.
  function automatic point_reply_t order_next_point(op_t op, coord_t r, coord_t c);
    point_reply_t res;
    int unsigned  sq_gap;
    int unsigned  best;
    int           dr;
    int           dc;
    int           pick;
    int           i;
    logic         found;
    res   = LOAD_OK;
    found = 1'b0;
    best  = 0;
    pick  = 0;
    if (op == OP_LOAD) begin
      n_load++;
      if (fill_count >= MAX_POINTS) begin
        n_full++;
        res.status = ST_FULL;
      end else begin
        pool_row[fill_count]  = r;
        pool_col[fill_count]  = c;
        pool_live[fill_count] = 1'b1;
        fill_count++;
        live_count++;
      end
      return res;
    end
    n_take++;
    for (i = 0; i < fill_count; i++) begin
      if (!pool_live[i]) continue;
      if (!have_last) begin
        found = 1'b1;
        pick  = i;
        break;
      end
      dr     = int'(last_row) - int'(pool_row[i]);
      dc     = int'(last_col) - int'(pool_col[i]);
      sq_gap = int'(dr * dr + dc * dc);
      // strict less-than keeps the earliest slot on a tie
      if (!found || sq_gap < best) begin
        found = 1'b1;
        best  = sq_gap;
        pick  = i;
      end
      if (best <= 1) break;
    end
    if (!found) begin
      n_empty++;
      res.status = ST_EMPTY;
      return res;
    end
    pool_live[pick] = 1'b0;
    live_count--;
    last_row  = pool_row[pick];
    last_col  = pool_col[pick];
    have_last = 1'b1;
    res.row   = last_row;
    res.col   = last_col;
    return res;
  endfunction

  // Printing is capped so a badly broken block cannot flood the log; all are counted.
  task automatic report_mismatch(string what);
    if (mismatches < 200) $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Scoreboard: predict on every accepted input beat, check every output beat
  // against the oldest awaited reply. Input side first so a same-edge beat on
  // both sides still pops the older entry.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    point_reply_t want;
    point_reply_t got;
    pinned_note_t note;
    if (!rst && in_bus.valid && in_bus.ready) begin
      want = order_next_point(in_bus.operation, in_bus.row, in_bus.col);
      if (pinned_notes.size() == 0) begin
        report_mismatch("input beat accepted that the sender never offered");
      end else begin
        note = pinned_notes.pop_front();
        if (note.pinned) want = note.reply;
      end
      awaited_replies.insert(awaited_replies.size(), want);
    end
    if (!rst && out_bus.valid && out_bus.ready) begin
      got = '{out_bus.out_row, out_bus.out_col, out_bus.status};
      if (awaited_replies.size() == 0) begin
        report_mismatch($sformatf("unexpected reply row %0d col %0d status %0d",
                                  got.row, got.col, got.status));
      end else begin
        want = awaited_replies.pop_front();
        if (got.row !== want.row)
          report_mismatch($sformatf("out_row %0d, expected %0d", got.row, want.row));
        if (got.col !== want.col)
          report_mismatch($sformatf("out_col %0d, expected %0d", got.col, want.col));
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: any beat on either side resets the count.
  // ---------------------------------------------------------------------------
  int quiet_cycles;

  always @(posedge clk) begin
    if (rst || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("no beat moved for %0d cycles, %0d replies outstanding",
               WATCHDOG_LIMIT, awaited_replies.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: switches between stall patterns at random, and on request holds
  // ready low for a long stretch counted here.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    rx_mode_t    mode;
    int          mode_left;
    int          hold_left;
    int unsigned phase;
    mode          = RX_FREE;
    mode_left     = 0;
    hold_left     = 0;
    phase         = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        phase++;
        case (mode)
          RX_FREE:     out_bus.ready <= 1'b1;
          RX_COIN:     out_bus.ready <= 1'($urandom_range(0, 1));
          RX_PERIODIC: out_bus.ready <= (phase % 4) != 3;
          default:     out_bus.ready <= $urandom_range(0, 3) == 0;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // One input beat. Called and returns at a falling edge; bursts of random
  // length with random gaps, some bursts long enough to run with no idling.
  task automatic send_beat(op_t op, coord_t r, coord_t c, logic pin, point_reply_t reply);
    int unsigned  gap;
    pinned_note_t note;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    note.pinned = pin;
    note.reply  = reply;
    pinned_notes.insert(pinned_notes.size(), note);
    in_bus.valid     <= 1'b1;
    in_bus.operation <= op;
    in_bus.row       <= r;
    in_bus.col       <= c;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  // Drop valid and wait until every awaited reply has come back.
  task automatic settle_pool();
    in_bus.valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (awaited_replies.size() != 0 || pinned_notes.size() != 0);
  endtask

  // Mostly a random walk from the previous load so that distance-0/1 hits are
  // common; the rest duplicates or jumps anywhere in the coordinate range.
  task automatic pick_load_point(output coord_t r, output coord_t c);
    case ($urandom_range(0, 9))
      0, 1: begin
        walk_row = coord_t'($urandom_range(0, 1023));
        walk_col = coord_t'($urandom_range(0, 1023));
      end
      2: ;
      default: begin
        walk_row = walk_row + coord_t'($urandom_range(0, 2)) - coord_t'(1);
        walk_col = walk_col + coord_t'($urandom_range(0, 2)) - coord_t'(1);
      end
    endcase
    r = walk_row;
    c = walk_col;
  endtask

  initial begin : sender
    probe_row_t pr;
    coord_t     r;
    coord_t     c;
    int         k;
    int         drain_n;

    in_bus.valid     = 1'b0;
    in_bus.operation = OP_LOAD;
    in_bus.row       = '0;
    in_bus.col       = '0;
    hold_req         = 1'b0;
    burst_left       = 0;
    mismatches       = 0;
    fill_count       = 0;
    live_count       = 0;
    last_row         = '0;
    last_col         = '0;
    have_last        = 1'b0;
    n_load           = 0;
    n_full           = 0;
    n_take           = 0;
    n_empty          = 0;
    walk_row         = coord_t'($urandom_range(0, 1023));
    walk_col         = coord_t'($urandom_range(0, 1023));
    for (k = 0; k < MAX_POINTS; k++) pool_live[k] = 1'b0;

    wait (!rst);
    @(negedge clk);

    // directed table
    for (k = 0; k < PROBE_ROWS; k++) begin
      pr = PROBE_TABLE[k];
      send_beat(pr.op, pr.row, pr.col, pr.pinned, pr.reply);
    end

    // random part, roughly 60 % loads
    for (k = 0; k < RANDOM_BEATS; k++) begin
      if (k == 40) begin
        // long receiver hold-off with the sender pushing back to back
        hold_req   = 1'b1;
        burst_left = 16;
      end
      if (k == 90) begin
        // quiet pool, then drain it completely and take once more on empty
        settle_pool();
        drain_n = live_count;
        repeat (drain_n + 1)
          send_beat(OP_TAKE, coord_t'($urandom_range(0, 1023)),
                    coord_t'($urandom_range(0, 1023)), 1'b0, LOAD_OK);
      end
      if ($urandom_range(0, 9) < 4) begin
        send_beat(OP_TAKE, coord_t'($urandom_range(0, 1023)),
                  coord_t'($urandom_range(0, 1023)), 1'b0, LOAD_OK);
      end else begin
        pick_load_point(r, c);
        send_beat(OP_LOAD, r, c, 1'b0, LOAD_OK);
      end
    end

    settle_pool();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("loads %0d (%0d dropped on a full pool), takes %0d (%0d on an empty pool)",
             n_load, n_full, n_take, n_empty);
    $display("slots filled %0d of %0d, %0d field mismatches",
             fill_count, MAX_POINTS, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[greedy_nearest_point_order_core.f]
rtl/gnpo_pkg.sv
rtl/gnpo_in_if.sv
rtl/gnpo_out_if.sv
rtl/greedy_nearest_point_order_core.sv
verif/greedy_nearest_point_order_core_tb.sv
